/* rtl/dbsc_pkg.sv */
`timescale 1ns / 1ps
// dbsc_pkg: shared types, codes and defaults of the diagonal bin seed counter
// used by dbsc_front, dbsc_queue, dbsc_back and diagonal_bin_seed_counter

package dbsc_pkg;

	localparam int DEF_NUM_BINS     = 65536;
	localparam int DEF_TOUCHED_CAP  = 4096;
	localparam int BIN_MAX_W        = 24;
	localparam int QDEPTH           = 4;
	localparam int CFG_IDX_W        = 4;
	localparam int CFG_DATA_W       = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SEED_LEN     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LOG_BIN_SIZE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CAND     = CFG_IDX_W'(3);

	localparam logic [15:0] RST_THRESHOLD    = 16'd16;
	localparam logic [3:0]  RST_SEED_LEN     = 4'd12;
	localparam logic [4:0]  RST_LOG_BIN_SIZE = 5'd7;
	localparam logic [15:0] RST_MAX_CAND     = 16'hFFFF;

	localparam logic OP_SEED     = 1'b0;
	localparam logic OP_FINISH   = 1'b1;
	localparam logic KIND_CAND   = 1'b0;
	localparam logic KIND_DONE   = 1'b1;

	typedef struct packed {
		logic [15:0] threshold;
		logic [3:0]  seed_len;
		logic [4:0]  log_bin_size;
		logic [15:0] cand_limit;
	} cfg_t;

	typedef struct packed {
		logic                 op;
		logic [BIN_MAX_W-1:0] bin;
		logic [31:0]          hit;
		logic [31:0]          offset;
	} qent_t;

	typedef struct packed {
		logic [15:0] count;
		logic [31:0] last;
	} bin_entry_t;

endpackage

/* rtl/dbsc_front.sv */
`timescale 1ns / 1ps
// dbsc_front: accepts words, maps seed hits to diagonal bins, drops out-of-range hits
// depends on dbsc_pkg

module dbsc_front #(
	parameter int NUM_BINS = dbsc_pkg::DEF_NUM_BINS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               op,
	input  logic [31:0]        hit_pos,
	input  logic [31:0]        query_offset,
	input  logic               hold,
	input  logic [4:0]         log_bin_size,
	input  logic               q_full,
	output logic               busy,
	output logic               q_push,
	output dbsc_pkg::qent_t    q_ent
);
	import dbsc_pkg::*;

	logic        vld_s1;
	logic        op_s1;
	logic [31:0] hit_s1;
	logic [31:0] off_s1;
	logic [32:0] diff;
	logic [31:0] shifted;
	logic        keep;
	logic        take;

	assign busy = hold || (vld_s1 && q_full);
	assign take = start && !busy;

	assign diff    = {1'b0, hit_s1} - {1'b0, off_s1};
	assign shifted = diff[31:0] >> log_bin_size;
	assign keep    = (op_s1 == OP_FINISH) || (!diff[32] && (shifted < 32'(NUM_BINS)));
	assign q_push  = vld_s1 && !q_full && keep;

	always_comb begin
		q_ent.op     = op_s1;
		q_ent.bin    = shifted[BIN_MAX_W-1:0];
		q_ent.hit    = hit_s1;
		q_ent.offset = off_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (vld_s1 && !q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= op;
			hit_s1 <= hit_pos;
			off_s1 <= query_offset;
		end
	end

endmodule

/* rtl/dbsc_queue.sv */
`timescale 1ns / 1ps
// dbsc_queue: short fifo of classified words between front and back
// depends on dbsc_pkg

module dbsc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dbsc_pkg::qent_t push_ent,
	input  logic            pop,
	output logic            full,
	output logic            valid,
	output dbsc_pkg::qent_t head
);
	import dbsc_pkg::*;

	localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	qent_t           ent_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   cnt_q;

	assign full  = (cnt_q == (QA_W+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !valid))
		else $error("pop from empty queue");
`endif

endmodule

/* rtl/dbsc_back.sv */
`timescale 1ns / 1ps
// dbsc_back: bin read-modify-write, touched list, finish sweep and reset clearing pass
// depends on dbsc_pkg

module dbsc_back #(
	parameter int NUM_BINS         = dbsc_pkg::DEF_NUM_BINS,
	parameter int TOUCHED_CAPACITY = dbsc_pkg::DEF_TOUCHED_CAP
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dbsc_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  dbsc_pkg::qent_t q_head,
	output logic            q_pop,
	output logic            clearing,
	output logic            strobe,
	output logic            kind,
	output logic [31:0]     cand_hit,
	output logic [31:0]     cand_offset,
	output logic [15:0]     cand_total
);
	import dbsc_pkg::*;

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int TL_AW = (TOUCHED_CAPACITY > 1) ? $clog2(TOUCHED_CAPACITY) : 1;
	localparam int TC_W  = $clog2(TOUCHED_CAPACITY + 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_CALC  = 7'b0001000,
		ST_WRITE = 7'b0010000,
		ST_FLUSH = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t           state_q;
	qent_t            cur_q;
	logic [BIN_W-1:0] clr_q;
	logic [TC_W-1:0]  tcount_q;
	logic [TC_W-1:0]  idx_q;
	logic             pend_q;
	logic [15:0]      cand_cnt_q;

	bin_entry_t       bin_mem [NUM_BINS];
	bin_entry_t       rd_q;
	logic [BIN_W-1:0] tl_mem [TOUCHED_CAPACITY];
	logic [BIN_W-1:0] tl_rd_q;

	logic [15:0]      curr_q;
	logic             skip_q;
	logic             fresh_q;
	logic             full_add_q;
	logic [3:0]       dist_lo_q;

	logic             strobe_q;
	logic             kind_q;
	logic [31:0]      hit_q;
	logic [31:0]      off_q;
	logic [15:0]      total_q;

	logic [BIN_W-1:0] cur_bin;
	logic [31:0]      ofs_gap;
	logic [3:0]       add;
	logic [16:0]      sum;
	logic [15:0]      next;
	logic             emit;
	logic             list_we;
	logic             mem_we;
	logic [BIN_W-1:0] mem_waddr;
	bin_entry_t       mem_wdata;

	assign cur_bin  = cur_q.bin[BIN_W-1:0];
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign clearing = (state_q == ST_CLEAR);

	assign ofs_gap = cur_q.offset - rd_q.last;
	assign add  = full_add_q ? cfg.seed_len : dist_lo_q;
	assign sum  = {1'b0, curr_q} + {13'b0, add};
	assign next = sum[16] ? 16'hFFFF : sum[15:0];
	assign emit = (state_q == ST_WRITE) && !skip_q && (next >= cfg.threshold)
		&& (cand_cnt_q < cfg.cand_limit);
	assign list_we = (state_q == ST_WRITE) && !skip_q && fresh_q
		&& (tcount_q < TC_W'(TOUCHED_CAPACITY));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_bin;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_FLUSH: begin
				mem_we    = pend_q;
				mem_waddr = tl_rd_q;
			end
			ST_WRITE: begin
				mem_we          = !skip_q;
				mem_wdata.count = next;
				mem_wdata.last  = cur_q.offset;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// bin store and touched list
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= bin_mem[cur_bin];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			tl_mem[tcount_q[TL_AW-1:0]] <= cur_bin;
		end
		tl_rd_q <= tl_mem[idx_q[TL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			tcount_q   <= '0;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			cand_cnt_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_W'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						if (q_head.op == OP_FINISH) begin
							idx_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (emit) begin
						strobe_q   <= 1'b1;
						cand_cnt_q <= cand_cnt_q + 1'b1;
					end
					if (list_we) begin
						tcount_q <= tcount_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (idx_q != tcount_q) begin
						idx_q  <= idx_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					strobe_q   <= 1'b1;
					tcount_q   <= '0;
					cand_cnt_q <= '0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (state_q == ST_CALC) begin
			curr_q     <= rd_q.count;
			skip_q     <= (rd_q.count >= cfg.threshold);
			fresh_q    <= (rd_q.count == 16'd0);
			full_add_q <= (rd_q.count == 16'd0) || (ofs_gap > {28'd0, cfg.seed_len});
			dist_lo_q  <= ofs_gap[3:0];
		end
		if (emit) begin
			kind_q  <= KIND_CAND;
			hit_q   <= cur_q.hit;
			off_q   <= cur_q.offset;
			total_q <= 16'd0;
		end else if (state_q == ST_DONE) begin
			kind_q  <= KIND_DONE;
			hit_q   <= 32'd0;
			off_q   <= 32'd0;
			total_q <= cand_cnt_q;
		end
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign cand_hit    = hit_q;
	assign cand_offset = off_q;
	assign cand_total  = total_q;

`ifndef SYNTHESIS
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n) strobe_q |=> !strobe_q)
		else $error("back-to-back result strobes");
	a_tcount_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tcount_q <= TC_W'(TOUCHED_CAPACITY))
		else $error("touched count beyond capacity");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !strobe_q)
		else $error("result during clearing pass");
	a_finish_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && kind_q == KIND_DONE) |-> (tcount_q == '0 && cand_cnt_q == '0))
		else $error("finish word left query state");
`endif

endmodule

/* rtl/diagonal_bin_seed_counter.sv */
`timescale 1ns / 1ps
// diagonal_bin_seed_counter: top level, config registers, front, queue and back
// depends on dbsc_pkg, dbsc_front, dbsc_queue, dbsc_back
//
// channel  direction  handshake              fields
// input    in         start high, busy low   op, hit_pos, query_offset
// result   out        strobe, one cycle      kind, cand_hit, cand_offset, cand_total
// config   in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// in the back a seed word goes through queue pop, bin read, compare and bin write, in that order
// in the back a finish word sweeps the touched list, clearing each listed bin, then reports its total
// after reset a clearing pass writes every bin, busy held high
// the front and a 4-word queue let new words in while the back is working
// the receiver cannot stall: each result shows for one cycle under strobe

module diagonal_bin_seed_counter #(
	parameter int NUM_BINS         = dbsc_pkg::DEF_NUM_BINS,
	parameter int TOUCHED_CAPACITY = dbsc_pkg::DEF_TOUCHED_CAP
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               op,
	input  logic [31:0]                        hit_pos,
	input  logic [31:0]                        query_offset,
	output logic                               strobe,
	output logic                               kind,
	output logic [31:0]                        cand_hit,
	output logic [31:0]                        cand_offset,
	output logic [15:0]                        cand_total,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dbsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dbsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dbsc_pkg::*;

	cfg_t  cfg_q;
	qent_t push_ent;
	qent_t head;
	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_valid;
	logic  clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= RST_THRESHOLD;
			cfg_q.seed_len     <= RST_SEED_LEN;
			cfg_q.log_bin_size <= RST_LOG_BIN_SIZE;
			cfg_q.cand_limit   <= RST_MAX_CAND;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD:    cfg_q.threshold    <= cfg_data;
				REG_SEED_LEN:     cfg_q.seed_len     <= cfg_data[3:0];
				REG_LOG_BIN_SIZE: cfg_q.log_bin_size <= cfg_data[4:0];
				REG_MAX_CAND:     cfg_q.cand_limit   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dbsc_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.hit_pos      (hit_pos),
		.query_offset (query_offset),
		.hold         (clearing),
		.log_bin_size (cfg_q.log_bin_size),
		.q_full       (q_full),
		.busy         (busy),
		.q_push       (q_push),
		.q_ent        (push_ent)
	);

	dbsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (push_ent),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (head)
	);

	dbsc_back #(
		.NUM_BINS         (NUM_BINS),
		.TOUCHED_CAPACITY (TOUCHED_CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_head      (head),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.strobe      (strobe),
		.kind        (kind),
		.cand_hit    (cand_hit),
		.cand_offset (cand_offset),
		.cand_total  (cand_total)
	);

endmodule

/* tb/sv/diagonal_bin_seed_counter_test.sv */
`timescale 1ns / 1ps
// diagonal_bin_seed_counter_test: self-checking bench for diagonal_bin_seed_counter
// mirrors the bin store and touched list and checks every report word in order
// depends on dbsc_pkg and diagonal_bin_seed_counter

module diagonal_bin_seed_counter_test;
	import dbsc_pkg::*;

	localparam int NBINS = DEF_NUM_BINS;
	localparam int LIST_CAP = DEF_TOUCHED_CAP;
	localparam int REG_COUNT = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [REG_COUNT] =
		'{REG_THRESHOLD, REG_SEED_LEN, REG_LOG_BIN_SIZE, REG_MAX_CAND};
	localparam logic [15:0] EXTREME_CFG [3][REG_COUNT] = '{
		'{16'd1, 16'd4, 16'd0, 16'hFFFF},
		'{16'hFFFF, 16'd15, 16'd20, 16'd0},
		'{16'd2, 16'd15, 16'd20, 16'd3}
	};
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;
	localparam int SETTLE_CYCLES = 32;
	localparam int TAIL_CYCLES = 64;
	localparam int RANDOM_WORDS = 1900;
	localparam int LANES = 6;
	localparam int PLAN_LEN = 23;
	localparam longint LIMIT_NS = 64'd30_000_000;

	typedef struct packed {
		logic        kind;
		logic [31:0] hit;
		logic [31:0] offset;
		logic [15:0] total;
	} report_t;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          data;
		logic                 op;
		logic [31:0]          hit;
		logic [31:0]          offset;
		bit                   typed;
		bit                   has_report;
		report_t              report;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  op;
	logic [31:0]           hit_pos;
	logic [31:0]           query_offset;
	logic                  strobe;
	logic                  kind;
	logic [31:0]           cand_hit;
	logic [31:0]           cand_offset;
	logic [15:0]           cand_total;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirror of the block state
	bit [15:0]   m_count [NBINS];
	bit [31:0]   m_last [NBINS];
	bit [15:0]   m_listed [LIST_CAP];
	int unsigned m_listed_n = 0;
	int unsigned m_cand_n = 0;
	bit [15:0]   c_thr = RST_THRESHOLD;
	bit [3:0]    c_kmer = RST_SEED_LEN;
	bit [4:0]    c_lbs = RST_LOG_BIN_SIZE;
	bit [15:0]   c_maxc = RST_MAX_CAND;

	report_t     awaited [$];
	int          fault_n = 0;
	plan_row_t   plan [PLAN_LEN];
	logic [31:0] lane_diag [LANES];
	logic [31:0] lane_off [LANES];

	diagonal_bin_seed_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.hit_pos(hit_pos),
		.query_offset(query_offset),
		.strobe(strobe),
		.kind(kind),
		.cand_hit(cand_hit),
		.cand_offset(cand_offset),
		.cand_total(cand_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void tally_word(input logic w_op, input logic [31:0] w_hit,
			input logic [31:0] w_off, output bit got, output report_t rep);
		bit [31:0]   bin;
		bit [31:0]   ofs_gap;
		int unsigned curr;
		int unsigned nxt;
		got = 1'b0;
		rep = '0;
		if (w_op == OP_FINISH) begin
			for (int i = 0; i < m_listed_n; i++) begin
				m_count[m_listed[i]] = '0;
				m_last[m_listed[i]] = '0;
			end
			rep = '{KIND_DONE, 32'd0, 32'd0, m_cand_n[15:0]};
			got = 1'b1;
			m_listed_n = 0;
			m_cand_n = 0;
		end else if (w_hit >= w_off) begin
			bin = (w_hit - w_off) >> c_lbs;
			if (bin < NBINS && m_count[bin[15:0]] < c_thr) begin
				curr = m_count[bin[15:0]];
				ofs_gap = w_off - m_last[bin[15:0]];
				if (curr == 0 || ofs_gap > c_kmer)
					nxt = curr + c_kmer;
				else
					nxt = curr + ofs_gap;
				if (nxt > COUNT_TOP)
					nxt = COUNT_TOP;
				m_count[bin[15:0]] = nxt[15:0];
				m_last[bin[15:0]] = w_off;
				if (nxt >= c_thr && m_cand_n < c_maxc) begin
					rep = '{KIND_CAND, w_hit, w_off, 16'd0};
					got = 1'b1;
					m_cand_n++;
				end
				if (curr == 0 && m_listed_n < LIST_CAP) begin
					m_listed[m_listed_n] = bin[15:0];
					m_listed_n++;
				end
			end
		end
	endfunction

	function automatic int draw_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_value(input logic [CFG_IDX_W-1:0] idx);
		int r;
		r = $urandom_range(0, 9);
		// any pattern, bits beyond the register width included
		if (r == 2)
			return 16'($urandom);
		case (idx)
			REG_THRESHOLD: begin
				return (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : 16'($urandom_range(8, 80));
			end
			REG_SEED_LEN: begin
				return (r == 0) ? 16'd4 : (r == 1) ? 16'd15 : 16'($urandom_range(4, 15));
			end
			REG_LOG_BIN_SIZE: begin
				return (r == 0) ? 16'd0 : (r == 1) ? 16'd20 : 16'($urandom_range(0, 10));
			end
			default: begin
				return (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 6));
			end
		endcase
	endfunction

	// a diagonal whose bins stay inside the store
	function automatic logic [31:0] new_diag();
		logic [31:0] top;
		top = (32'h8000_0000 >> c_lbs) - 1;
		if (top > NBINS - 1)
			top = NBINS - 1;
		if ($urandom_range(0, 1) && top > 31)
			top = 31;
		return 32'($urandom_range(0, top)) << c_lbs;
	endfunction

	function automatic logic [31:0] draw_jitter();
		logic [31:0] mask;
		mask = (c_lbs >= 10) ? 32'd1023 : (32'd1 << c_lbs) - 1;
		return $urandom_range(0, mask);
	endfunction

	task automatic send_word(input logic w_op, input logic [31:0] w_hit,
			input logic [31:0] w_off, input bit typed = 1'b0,
			input bit typed_has = 1'b0, input report_t typed_rep = '0);
		bit      got;
		report_t rep;
		@(negedge clk);
		start <= 1'b1;
		cfg_valid <= 1'b0;
		op <= w_op;
		hit_pos <= w_hit;
		query_offset <= w_off;
		do @(posedge clk); while (busy);
		tally_word(w_op, w_hit, w_off, got, rep);
		if (typed) begin
			got = typed_has;
			rep = typed_rep;
		end
		if (got)
			awaited.push_back(rep);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic settle(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		cfg_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THRESHOLD:    c_thr = data;
			REG_SEED_LEN:     c_kmer = data[3:0];
			REG_LOG_BIN_SIZE: c_lbs = data[4:0];
			REG_MAX_CAND:     c_maxc = data;
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		report_t seen;
		report_t want;
		if (arst_n && strobe) begin
			seen = '{kind, cand_hit, cand_offset, cand_total};
			if (awaited.size() == 0) begin
				fault_n++;
				if (fault_n <= 10)
					$display("%0t unexpected word: kind %0d hit %h offset %h total %0d",
						$realtime, seen.kind, seen.hit, seen.offset, seen.total);
			end else begin
				want = awaited.pop_front();
				if (seen.kind !== want.kind || seen.hit !== want.hit ||
						seen.offset !== want.offset || seen.total !== want.total) begin
					fault_n++;
					if (fault_n <= 10) begin
						$display("%0t mismatch: exp kind %0d hit %h offset %h total %0d",
							$realtime, want.kind, want.hit, want.offset, want.total);
						$display("%0t           got kind %0d hit %h offset %h total %0d",
							$realtime, seen.kind, seen.hit, seen.offset, seen.total);
					end
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("FAIL diagonal_bin_seed_counter");
		$finish;
	end

	initial begin
		int          n;
		int          r;
		int          j;
		int          len;
		int          phase;
		int          done_words;
		bit          burst;

		arst_n = 1'b0;
		start = 1'b0;
		op = OP_SEED;
		hit_pos = '0;
		query_offset = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// is_cfg, index, data, op, hit, offset, typed, has report, report
		plan = '{
			'{0, '0, '0, OP_FINISH, 32'h0, 32'h0, 1, 1, '{KIND_DONE, 32'h0, 32'h0, 16'd0}},
			'{0, '0, '0, OP_SEED, 32'h0, 32'h0, 0, 0, '0},
			'{0, '0, '0, OP_SEED, 32'h4, 32'h4, 1, 1, '{KIND_CAND, 32'h4, 32'h4, 16'd0}},
			'{0, '0, '0, OP_SEED, 32'h8, 32'h8, 1, 0, '0},
			'{0, '0, '0, OP_SEED, 32'h0, 32'hFFFF_FFFF, 1, 0, '0},
			'{0, '0, '0, OP_SEED, 32'hFFFF_FFFF, 32'h0, 1, 0, '0},
			'{0, '0, '0, OP_SEED, 32'h007F_FFFF, 32'h0, 0, 0, '0},
			'{0, '0, '0, OP_SEED, 32'hFFFF_FFFF, 32'hFF80_0000, 1, 1,
				'{KIND_CAND, 32'hFFFF_FFFF, 32'hFF80_0000, 16'd0}},
			'{0, '0, '0, OP_SEED, 32'd148, 32'd20, 0, 0, '0},
			'{0, '0, '0, OP_SEED, 32'd138, 32'd10, 0, 0, '0},
			'{0, '0, '0, OP_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
				'{KIND_DONE, 32'h0, 32'h0, 16'd3}},
			'{1, REG_THRESHOLD, 16'd0, OP_SEED, 32'h0, 32'h0, 0, 0, '0},
			'{0, '0, '0, OP_SEED, 32'h0, 32'h0, 1, 0, '0},
			'{0, '0, '0, OP_FINISH, 32'h0, 32'h0, 1, 1, '{KIND_DONE, 32'h0, 32'h0, 16'd0}},
			'{1, REG_THRESHOLD, 16'd4, OP_SEED, 32'h0, 32'h0, 0, 0, '0},
			'{1, REG_MAX_CAND, 16'd1, OP_SEED, 32'h0, 32'h0, 0, 0, '0},
			'{0, '0, '0, OP_SEED, 32'h0, 32'h0, 1, 1, '{KIND_CAND, 32'h0, 32'h0, 16'd0}},
			'{0, '0, '0, OP_SEED, 32'd256, 32'h0, 0, 0, '0},
			'{0, '0, '0, OP_FINISH, 32'h0, 32'h0, 1, 1, '{KIND_DONE, 32'h0, 32'h0, 16'd1}},
			'{1, REG_SPARE, 16'hFFFF, OP_SEED, 32'h0, 32'h0, 0, 0, '0},
			'{0, '0, '0, OP_SEED, 32'h0, 32'h0, 1, 1, '{KIND_CAND, 32'h0, 32'h0, 16'd0}},
			'{0, '0, '0, OP_SEED, 32'd512, 32'h0, 0, 0, '0},
			'{0, '0, '0, OP_FINISH, 32'h0, 32'h0, 1, 1, '{KIND_DONE, 32'h0, 32'h0, 16'd1}}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < PLAN_LEN; n++) begin
			if (plan[n].is_cfg) begin
				settle(SETTLE_CYCLES);
				write_reg(plan[n].idx, plan[n].data);
			end else begin
				send_word(plan[n].op, plan[n].hit, plan[n].offset, plan[n].typed,
					plan[n].has_report, plan[n].report);
				pause(draw_gap(1'b0));
			end
		end

		phase = 0;
		done_words = 0;
		while (done_words < RANDOM_WORDS) begin
			settle(SETTLE_CYCLES);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
					16'($urandom));
			for (r = 0; r < REG_COUNT; r++)
				write_reg(REG_ORDER[r],
					(phase < 3) ? EXTREME_CFG[phase][r] : pick_value(REG_ORDER[r]));
			burst = ($urandom_range(0, 3) == 0);
			for (j = 0; j < LANES; j++) begin
				lane_diag[j] = new_diag();
				lane_off[j] = $urandom_range(0, 32'h4000_0000);
			end
			len = $urandom_range(20, 120);
			for (n = 0; n < len; n++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					send_word(OP_FINISH, $urandom, $urandom);
					done_words++;
				end else if (r < 16) begin
					// hit before offset or bin beyond the store, mostly
					send_word(OP_SEED, $urandom, $urandom);
					done_words++;
				end else begin
					j = $urandom_range(0, LANES - 1);
					if (r < 20)
						lane_diag[j] = new_diag();
					if ($urandom_range(0, 9) == 0)
						lane_off[j] -= $urandom_range(1, 40);
					else
						lane_off[j] += $urandom_range(0, c_kmer + 4);
					send_word(OP_SEED, lane_off[j] + lane_diag[j] + draw_jitter(), lane_off[j]);
					done_words++;
				end
				pause(draw_gap(burst));
			end
			send_word(OP_FINISH, $urandom, $urandom);
			done_words++;
			phase++;
		end

		settle(TAIL_CYCLES);
		if (fault_n == 0 && awaited.size() == 0)
			$display("PASS diagonal_bin_seed_counter");
		else
			$display("FAIL diagonal_bin_seed_counter");
		$finish;
	end

endmodule

/* sim.f */
rtl/dbsc_pkg.sv
rtl/dbsc_front.sv
rtl/dbsc_queue.sv
rtl/dbsc_back.sv
rtl/diagonal_bin_seed_counter.sv
tb/sv/diagonal_bin_seed_counter_test.sv
